### design/cle_pkg.sv
package cle_pkg;

    // default line size, terminator included
    localparam int LINE_MAX_DEF = 256;

    // character codes
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    // command codes
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } in_word_t;

    typedef struct packed {
        logic       has_echo;
        logic [7:0] echo_char;
        logic       last;
        logic       line_done;
        logic [7:0] line_length;
        logic [7:0] read_data;
    } out_word_t;

    // what one input word turns into on the result side
    typedef enum logic [2:0] {
        KIND_SILENT,
        KIND_ECHO,
        KIND_READ,
        KIND_CRLF,
        KIND_RUBOUT
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] echo_char;
        logic       done;
        logic [7:0] length;
        logic [7:0] read_data;
    } desc_t;

endpackage

### design/cle_edit.sv
module cle_edit #(
    parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cle_pkg::in_word_t s_payload,
    output logic              desc_valid,
    output cle_pkg::desc_t    desc,
    input  logic              desc_pop
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int DEPTH = 1 << AW;
    localparam logic [AW:0] LIMIT = (AW + 1)'(LINE_MAX - 1);

    logic [7:0] line_mem [DEPTH];

    logic [AW-1:0] count_reg, count_next;
    logic          cr_pending_reg, cr_pending_next;
    logic          closed_reg, closed_next;
    logic          desc_valid_reg;

    cle_pkg::kind_t kind_reg, kind_next;
    logic [7:0]     echo_reg, echo_next;
    logic           done_reg, done_next;
    logic [AW-1:0]  len_reg;
    logic           hit_reg, hit_next;
    logic [7:0]     rd_data_reg;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] base;
    logic [AW:0]   inc;
    logic [7:0]    ch;
    logic          printable;

    assign s_ready = !desc_valid_reg || desc_pop;
    assign accept  = s_valid && s_ready;
    assign ch      = s_payload.rx_byte;
    assign base    = closed_reg ? '0 : count_reg;
    assign inc     = {1'b0, base} + (AW + 1)'(1);
    assign printable = (ch >= cle_pkg::CH_PRINT_LO && ch <= cle_pkg::CH_PRINT_HI)
                       || ch == cle_pkg::CH_TAB;

    // editing decision for one word
    always_comb begin
        count_next      = count_reg;
        cr_pending_next = cr_pending_reg;
        closed_next     = closed_reg;
        kind_next       = cle_pkg::KIND_SILENT;
        echo_next       = '0;
        done_next       = 1'b0;
        hit_next        = 1'b0;
        wr_en           = 1'b0;
        if (s_payload.command == cle_pkg::CMD_READ) begin
            kind_next = cle_pkg::KIND_READ;
            hit_next  = s_payload.read_index < 8'(count_reg);
        end else if (ch == cle_pkg::CH_LF && cr_pending_reg) begin
            // lf right after cr is swallowed
            cr_pending_next = 1'b0;
        end else begin
            count_next      = base;
            closed_next     = 1'b0;
            cr_pending_next = (ch == cle_pkg::CH_CR);
            priority if (ch == cle_pkg::CH_CR || ch == cle_pkg::CH_LF) begin
                closed_next = 1'b1;
                kind_next   = cle_pkg::KIND_CRLF;
                done_next   = 1'b1;
            end else if (ch == cle_pkg::CH_DEL) begin
                if (base != '0) begin
                    count_next = base - AW'(1);
                    kind_next  = cle_pkg::KIND_RUBOUT;
                end
            end else begin
                wr_en       = 1'b1;
                count_next  = inc[AW-1:0];
                done_next   = (inc >= LIMIT);
                closed_next = (inc >= LIMIT);
                if (printable) begin
                    kind_next = cle_pkg::KIND_ECHO;
                    echo_next = ch;
                end
            end
        end
    end

    // editor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            cr_pending_reg <= 1'b0;
            closed_reg     <= 1'b0;
            desc_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg      <= count_next;
                cr_pending_reg <= cr_pending_next;
                closed_reg     <= closed_next;
            end
            if (accept) begin
                desc_valid_reg <= 1'b1;
            end else if (desc_pop) begin
                desc_valid_reg <= 1'b0;
            end
        end
    end

    // descriptor payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kind_next;
            echo_reg <= echo_next;
            done_reg <= done_next;
            len_reg  <= count_next;
            hit_reg  <= hit_next;
        end
    end

    // line memory, registered read
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            line_mem[base] <= ch;
        end
        if (accept) begin
            rd_data_reg <= line_mem[s_payload.read_index[AW-1:0]];
        end
    end

    assign desc_valid     = desc_valid_reg;
    assign desc.kind      = kind_reg;
    assign desc.echo_char = echo_reg;
    assign desc.done      = done_reg;
    assign desc.length    = 8'(len_reg);
    assign desc.read_data = hit_reg ? rd_data_reg : 8'h00;

endmodule

### design/cle_emit.sv
module cle_emit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               desc_valid,
    input  cle_pkg::desc_t     desc,
    output logic               desc_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output cle_pkg::out_word_t m_payload
);

    logic [1:0]         beat_reg, beat_next;
    logic               m_valid_reg;
    cle_pkg::out_word_t out_reg, out_next;
    logic               out_free;
    logic               advance;
    logic               last_beat;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = desc_valid && out_free;
    assign desc_pop = advance && last_beat;

    // build the word for the current beat
    always_comb begin
        out_next             = '0;
        out_next.line_length = desc.length;
        last_beat            = 1'b1;
        unique case (desc.kind)
            cle_pkg::KIND_SILENT: begin
                out_next.line_done = desc.done;
            end
            cle_pkg::KIND_ECHO: begin
                out_next.has_echo  = 1'b1;
                out_next.echo_char = desc.echo_char;
                out_next.line_done = desc.done;
            end
            cle_pkg::KIND_READ: begin
                out_next.read_data = desc.read_data;
            end
            cle_pkg::KIND_CRLF: begin
                last_beat          = (beat_reg == 2'd1);
                out_next.has_echo  = 1'b1;
                out_next.echo_char = last_beat ? cle_pkg::CH_LF : cle_pkg::CH_CR;
                out_next.line_done = last_beat;
            end
            cle_pkg::KIND_RUBOUT: begin
                last_beat          = (beat_reg == 2'd2);
                out_next.has_echo  = 1'b1;
                out_next.echo_char = (beat_reg == 2'd1) ? cle_pkg::CH_SP : cle_pkg::CH_BS;
            end
            default: begin
                out_next.line_done = 1'b0;
            end
        endcase
        out_next.last = last_beat;
        beat_next     = last_beat ? 2'd0 : beat_reg + 2'd1;
    end

    // beat counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                beat_reg <= beat_next;
            end
            if (out_free) begin
                m_valid_reg <= desc_valid;
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

### design/console_line_editor.sv
// path: a result word is held in the cle_edit descriptor register, then in the cle_emit output register
// throughput: one input word per cycle when it yields one result and m_ready is high;
// cr/lf gives cr and lf words, a rubout gives bs, space, bs, paced by the one word per cycle output
// register; a read word returns the stored byte via a registered line memory read
// reset: aresetn is synchronous, clears line length, cr mark, line state and valids;
// the line memory is not cleared and is ready right after reset
module console_line_editor #(
    parameter int LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cle_pkg::in_word_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output cle_pkg::out_word_t m_payload
);

    logic           desc_valid;
    logic           desc_pop;
    cle_pkg::desc_t desc;

    // line editing and storage
    cle_edit #(
        .LINE_MAX (LINE_MAX)
    ) u_edit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_pop   (desc_pop)
    );

    // result word sequencing
    cle_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_pop   (desc_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

### bench/tb_top.sv
module tb_top;

    localparam int LINE_SIZE      = cle_pkg::LINE_MAX_DEF;
    localparam int LINE_LIMIT     = LINE_SIZE - 1;
    localparam int ITEMS_TOTAL    = 380;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    cle_pkg::in_word_t  s_payload = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    cle_pkg::out_word_t m_payload;

    console_line_editor #(.LINE_MAX(LINE_SIZE)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // mirror of the editor state
    logic [7:0] ed_mem [LINE_SIZE];
    int         ed_len;
    bit         ed_cr;
    bit         ed_closed;

    // words still owed by the editor, oldest first
    cle_pkg::out_word_t line_expect [$];
    cle_pkg::out_word_t typed_words [$];
    int                 failures    = 0;
    int                 items_sent;
    int                 burst_left;
    int                 idle_cycles = 0;
    int                 words_seen  = 0;

    function automatic cle_pkg::out_word_t echo_word(logic has, logic [7:0] ch, logic last,
                                                     logic done, logic [7:0] rd);
        cle_pkg::out_word_t r;
        r.has_echo    = has;
        r.echo_char   = ch;
        r.last        = last;
        r.line_done   = done;
        r.line_length = ed_len[7:0];
        r.read_data   = rd;
        return r;
    endfunction

    // advance the mirror by one word and list the result words it causes
    function automatic void edit_line(input cle_pkg::in_word_t w,
                                      output cle_pkg::out_word_t res[$]);
        logic [7:0] rd;
        logic       done;
        logic       shown;
        res = {};
        if (w.command == cle_pkg::CMD_READ) begin
            rd = (int'(w.read_index) < ed_len) ? ed_mem[w.read_index] : 8'h00;
            res.push_back(echo_word(1'b0, 8'h00, 1'b1, 1'b0, rd));
            return;
        end
        // lf right after cr is swallowed
        if (w.rx_byte == cle_pkg::CH_LF && ed_cr) begin
            ed_cr = 1'b0;
            res.push_back(echo_word(1'b0, 8'h00, 1'b1, 1'b0, 8'h00));
            return;
        end
        if (ed_closed) begin
            ed_len    = 0;
            ed_closed = 1'b0;
        end
        ed_cr = (w.rx_byte == cle_pkg::CH_CR);
        if (w.rx_byte == cle_pkg::CH_CR || w.rx_byte == cle_pkg::CH_LF) begin
            ed_closed = 1'b1;
            res.push_back(echo_word(1'b1, cle_pkg::CH_CR, 1'b0, 1'b0, 8'h00));
            res.push_back(echo_word(1'b1, cle_pkg::CH_LF, 1'b1, 1'b1, 8'h00));
            return;
        end
        if (w.rx_byte == cle_pkg::CH_DEL) begin
            if (ed_len == 0) begin
                res.push_back(echo_word(1'b0, 8'h00, 1'b1, 1'b0, 8'h00));
                return;
            end
            ed_len--;
            res.push_back(echo_word(1'b1, cle_pkg::CH_BS, 1'b0, 1'b0, 8'h00));
            res.push_back(echo_word(1'b1, cle_pkg::CH_SP, 1'b0, 1'b0, 8'h00));
            res.push_back(echo_word(1'b1, cle_pkg::CH_BS, 1'b1, 1'b0, 8'h00));
            return;
        end
        // ordinary byte goes into the line
        ed_mem[ed_len] = w.rx_byte;
        ed_len++;
        done  = (ed_len >= LINE_LIMIT);
        shown = (w.rx_byte >= cle_pkg::CH_PRINT_LO && w.rx_byte <= cle_pkg::CH_PRINT_HI) ||
                w.rx_byte == cle_pkg::CH_TAB;
        if (done)
            ed_closed = 1'b1;
        if (shown)
            res.push_back(echo_word(1'b1, w.rx_byte, 1'b1, done, 8'h00));
        else
            res.push_back(echo_word(1'b0, 8'h00, 1'b1, done, 8'h00));
    endfunction

    // text byte: mostly printable, some tab and non-printable, never cr or lf
    function automatic logic [7:0] pick_text();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            b = cle_pkg::CH_TAB;
        end else if (r < 3) begin
            do b = 8'($urandom_range(0, 31));
            while (b == cle_pkg::CH_CR || b == cle_pkg::CH_LF);
        end else if (r < 5) begin
            b = 8'($urandom_range(128, 255));
        end else begin
            b = 8'($urandom_range(32, 126));
        end
        return b;
    endfunction

    // offer one word in bursts with random gaps, then predict its results
    task automatic send_word(input cle_pkg::in_word_t w, input bit use_typed);
        cle_pkg::out_word_t pred [$];
        int                 gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= w;
        do @(posedge aclk); while (!s_ready);
        edit_line(w, pred);
        if (use_typed)
            pred = typed_words;
        foreach (pred[i])
            line_expect.push_back(pred[i]);
        items_sent++;
    endtask

    task automatic send_rx(input logic [7:0] b);
        cle_pkg::in_word_t w;
        w.command    = cle_pkg::CMD_RX;
        w.rx_byte    = b;
        w.read_index = 8'($urandom_range(0, 255));
        send_word(w, 1'b0);
    endtask

    task automatic send_read(input int idx);
        cle_pkg::in_word_t w;
        w.command    = cle_pkg::CMD_READ;
        w.rx_byte    = 8'($urandom_range(0, 255));
        w.read_index = 8'(idx);
        send_word(w, 1'b0);
    endtask

    // hold off the sender until every owed word has come back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (line_expect.size() != 0);
    endtask

    // short line with edits and reads, then some kind of terminator, a random byte or nothing
    task automatic send_line();
        int n;
        int r;
        n = $urandom_range(0, 12);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_rx(cle_pkg::CH_DEL);
            else if (r < 18)
                send_read(r < 13 ? $urandom_range(0, 255) : $urandom_range(0, ed_len));
            else
                send_rx(pick_text());
        end
        case ($urandom_range(0, 9))
            0, 1, 2: send_rx(cle_pkg::CH_CR);
            3, 4: begin
                send_rx(cle_pkg::CH_CR);
                send_rx(cle_pkg::CH_LF);
            end
            5, 6: send_rx(cle_pkg::CH_LF);
            7: send_rx(8'($urandom_range(0, 255)));
            8: begin
                send_rx(cle_pkg::CH_CR);
                send_rx(cle_pkg::CH_LF);
                send_rx(cle_pkg::CH_LF);
            end
            default: ;
        endcase
    endtask

    // directed words; typed rows carry their own expected result words
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic [7:0] idx;
        logic       typed;
        logic [1:0] n;
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
        logic       done;
        logic [7:0] len;
        logic [7:0] rd;
    } step_t;

    // each row: command, byte, index, typed, then count, echoes, done, length, data
    step_t script [26] = '{
        '{cle_pkg::CMD_READ, 8'h00, 8'h00, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_DEL, 8'hA5, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'h00},
        '{cle_pkg::CMD_RX, 8'h41, 8'h5A, 1'b1,
          2'd1, 8'h41, 8'h00, 8'h00, 1'b0, 8'd1, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_PRINT_LO, 8'hFF, 1'b1,
          2'd1, cle_pkg::CH_PRINT_LO, 8'h00, 8'h00, 1'b0, 8'd2, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_PRINT_HI, 8'h00, 1'b1,
          2'd1, cle_pkg::CH_PRINT_HI, 8'h00, 8'h00, 1'b0, 8'd3, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_TAB, 8'h00, 1'b1,
          2'd1, cle_pkg::CH_TAB, 8'h00, 8'h00, 1'b0, 8'd4, 8'h00},
        '{cle_pkg::CMD_RX, 8'h00, 8'h00, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd5, 8'h00},
        '{cle_pkg::CMD_RX, 8'hFF, 8'h00, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd6, 8'h00},
        '{cle_pkg::CMD_RX, 8'h80, 8'h00, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd7, 8'h00},
        '{cle_pkg::CMD_RX, 8'h1F, 8'h00, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd8, 8'h00},
        '{cle_pkg::CMD_READ, 8'hFF, 8'h00, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd8, 8'h41},
        '{cle_pkg::CMD_READ, 8'h00, 8'h07, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd8, 8'h1F},
        '{cle_pkg::CMD_READ, 8'h00, 8'h08, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd8, 8'h00},
        '{cle_pkg::CMD_READ, 8'h00, 8'hFF, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd8, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_DEL, 8'h00, 1'b1,
          2'd3, cle_pkg::CH_BS, cle_pkg::CH_SP, cle_pkg::CH_BS, 1'b0, 8'd7, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_CR, 8'h00, 1'b1,
          2'd2, cle_pkg::CH_CR, cle_pkg::CH_LF, 8'h00, 1'b1, 8'd7, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_LF, 8'h00, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd7, 8'h00},
        '{cle_pkg::CMD_READ, 8'h00, 8'h02, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd7, 8'h7E},
        '{cle_pkg::CMD_RX, cle_pkg::CH_LF, 8'h00, 1'b1,
          2'd2, cle_pkg::CH_CR, cle_pkg::CH_LF, 8'h00, 1'b1, 8'd0, 8'h00},
        '{cle_pkg::CMD_RX, 8'h7A, 8'h00, 1'b0,
          2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_CR, 8'h00, 1'b1,
          2'd2, cle_pkg::CH_CR, cle_pkg::CH_LF, 8'h00, 1'b1, 8'd1, 8'h00},
        '{cle_pkg::CMD_RX, 8'h42, 8'h00, 1'b0,
          2'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_LF, 8'h00, 1'b1,
          2'd2, cle_pkg::CH_CR, cle_pkg::CH_LF, 8'h00, 1'b1, 8'd1, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_CR, 8'h00, 1'b1,
          2'd2, cle_pkg::CH_CR, cle_pkg::CH_LF, 8'h00, 1'b1, 8'd0, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_CR, 8'h00, 1'b1,
          2'd2, cle_pkg::CH_CR, cle_pkg::CH_LF, 8'h00, 1'b1, 8'd0, 8'h00},
        '{cle_pkg::CMD_RX, cle_pkg::CH_DEL, 8'h00, 1'b1,
          2'd1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'h00}
    };

    // stimulus
    initial begin
        bit long_done;
        int r;
        ed_len     = 0;
        ed_cr      = 1'b0;
        ed_closed  = 1'b0;
        items_sent = 0;
        burst_left = 0;
        long_done  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows
        foreach (script[i]) begin
            cle_pkg::in_word_t  w;
            cle_pkg::out_word_t t;
            logic [7:0]         e;
            w.command    = script[i].cmd;
            w.rx_byte    = script[i].data;
            w.read_index = script[i].idx;
            typed_words  = {};
            for (int k = 0; k < int'(script[i].n); k++) begin
                e = (k == 0) ? script[i].e0 : (k == 1) ? script[i].e1 : script[i].e2;
                t.has_echo    = (e != 8'h00);
                t.echo_char   = e;
                t.last        = (k == int'(script[i].n) - 1);
                t.line_done   = script[i].done && t.last;
                t.line_length = script[i].len;
                t.read_data   = script[i].rd;
                typed_words.push_back(t);
            end
            send_word(w, script[i].typed);
        end
        settle();

        // random lines, with one line typed until it fills up
        while (items_sent < ITEMS_TOTAL) begin
            if (!long_done && items_sent >= 60) begin
                while (!(ed_closed && ed_len == LINE_LIMIT)) begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        send_rx(cle_pkg::CH_DEL);
                    else if (r < 8)
                        send_read($urandom_range(0, 255));
                    else
                        send_rx(pick_text());
                end
                send_read(LINE_LIMIT - 1);
                send_read(LINE_LIMIT);
                settle();
                long_done = 1'b1;
            end else begin
                send_line();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver stalls, pattern picked anew whenever the low six bits of stall_tick are zero
    logic [7:0] stall_tick = '0;
    logic [1:0] stall_mode = '0;

    always @(posedge aclk) begin
        stall_tick <= stall_tick + 8'd1;
        if (stall_tick[5:0] == 6'd0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= ($urandom_range(0, 3) != 0);
            2'd2: m_ready <= (stall_tick[3:0] < 4'd11);
            default: m_ready <= stall_tick[1];
        endcase
    end

    // compare each result word with the oldest owed word
    always @(posedge aclk) begin
        cle_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen <= words_seen + 1;
            if (line_expect.size() == 0) begin
                if (failures < 10)
                    $display("word %0d: unexpected result echo=%b/%h len=%h data=%h",
                             words_seen, m_payload.has_echo, m_payload.echo_char,
                             m_payload.line_length, m_payload.read_data);
                failures <= failures + 1;
            end else begin
                want = line_expect.pop_front();
                if (m_payload.has_echo !== want.has_echo ||
                    m_payload.echo_char !== want.echo_char ||
                    m_payload.last !== want.last ||
                    m_payload.line_done !== want.line_done ||
                    m_payload.line_length !== want.line_length ||
                    m_payload.read_data !== want.read_data) begin
                    if (failures < 10)
                        $display({"word %0d: expected echo=%b/%h last=%b done=%b len=%h ",
                                  "data=%h, got echo=%b/%h last=%b done=%b len=%h data=%h"},
                                 words_seen, want.has_echo, want.echo_char, want.last,
                                 want.line_done, want.line_length, want.read_data,
                                 m_payload.has_echo, m_payload.echo_char, m_payload.last,
                                 m_payload.line_done, m_payload.line_length,
                                 m_payload.read_data);
                    failures <= failures + 1;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule
